[sv/lis_pkg.sv]
package lis_pkg;

    localparam int MAX_ITEMS = 1024;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_TAIL  = 2'd2,
        CMD_QLEN  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SRCH_RD,
        S_SRCH_WAIT,
        S_SRCH_CMP,
        S_PUSH_RD,
        S_PUSH_WAIT,
        S_PUSH_WR,
        S_POP_RD,
        S_POP_WAIT,
        S_POP_B_RD,
        S_POP_B_WAIT,
        S_TAIL_RD,
        S_TAIL_WAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;       // capture input transaction
        logic srch_init;
        logic srch_rd;    // issue tail read at mid
        logic srch_step;  // update lo/hi from read data
        logic top_rd;     // read level_top at found level
        logic push_wr;    // write all stores for push
        logic pop_rd;     // read element entry of the last element
        logic pop_b_rd;   // read store entry of element beneath
        logic pop_wr;     // write restored tail/top, or shrink levels
        logic tail_rd;    // read tail for cmd 2
        logic tail_cap;
        logic finish;     // form result
    } t_ctrl;

    typedef struct packed {
        t_cmd cmd;
        logic full;
        logic empty;
        logic range_bad;
        logic srch_done;
        logic new_level;
        logic below_zero;
    } t_stat;

endpackage

[sv/lis_ram.sv]
module lis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[sv/lis_ctrl.sv]
module lis_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  lis_pkg::t_stat i_stat,
    output lis_pkg::t_ctrl o_ctrl
);
    import lis_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:       if (i_in_valid) n_state = S_DISPATCH;
            S_DISPATCH: begin
                case (i_stat.cmd)
                    CMD_PUSH: n_state = i_stat.full ? S_DONE : S_SRCH_RD;
                    CMD_POP:  n_state = i_stat.empty ? S_DONE : S_POP_RD;
                    CMD_TAIL: n_state = i_stat.range_bad ? S_DONE : S_TAIL_RD;
                    default:  n_state = S_SRCH_RD;
                endcase
            end
            S_SRCH_RD:    n_state = i_stat.srch_done ?
                              ((i_stat.cmd == CMD_PUSH) ? S_PUSH_RD : S_DONE) : S_SRCH_WAIT;
            S_SRCH_WAIT:  n_state = S_SRCH_CMP;
            S_SRCH_CMP:   n_state = S_SRCH_RD;
            S_PUSH_RD:    n_state = S_PUSH_WAIT;
            S_PUSH_WAIT:  n_state = S_PUSH_WR;
            S_PUSH_WR:    n_state = S_DONE;
            S_POP_RD:     n_state = S_POP_WAIT;
            S_POP_WAIT:   n_state = S_POP_B_RD;
            S_POP_B_RD:   n_state = i_stat.below_zero ? S_DONE : S_POP_B_WAIT;
            S_POP_B_WAIT: n_state = S_DONE;
            S_TAIL_RD:    n_state = S_TAIL_WAIT;
            S_TAIL_WAIT:  n_state = S_DONE;
            S_DONE:       if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default:      n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        o_in_ready = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_ctrl.load = i_in_valid;
            end
            S_DISPATCH:   o_ctrl.srch_init = 1'b1;
            S_SRCH_RD:    o_ctrl.srch_rd = 1'b1;
            S_SRCH_CMP:   o_ctrl.srch_step = 1'b1;
            S_PUSH_RD:    o_ctrl.top_rd = 1'b1;
            S_PUSH_WR:    o_ctrl.push_wr = 1'b1;
            S_POP_RD:     o_ctrl.pop_rd = 1'b1;
            S_POP_B_RD: begin
                o_ctrl.pop_b_rd = 1'b1;
                o_ctrl.pop_wr = i_stat.below_zero;
            end
            S_POP_B_WAIT: o_ctrl.pop_wr = 1'b1;
            S_TAIL_WAIT:  o_ctrl.tail_cap = 1'b1;
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_ctrl.finish = 1'b1;
                    n_out_valid = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
endmodule

[sv/lis_dp.sv]
module lis_dp #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_strict_mode,
    input  logic [1:0]             i_cmd,
    input  logic [VALUE_WIDTH-1:0] i_value,
    input  logic [10:0]            i_length_k,
    input  lis_pkg::t_ctrl         i_ctrl,
    output lis_pkg::t_stat         o_stat,
    output logic [1:0]             o_status,
    output logic [10:0]            o_item_total,
    output logic [10:0]            o_lis_length,
    output logic [10:0]            o_ending_length,
    output logic [VALUE_WIDTH-1:0] o_value_out
);
    import lis_pkg::*;

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);

    t_cmd             r_cmd;
    t_status          r_status;
    logic [VALUE_WIDTH-1:0] r_value;
    logic [10:0]      r_k;
    logic [CW-1:0]    r_elem_cnt, r_lvl_cnt;
    logic [CW-1:0]    r_lo, r_hi;
    logic [AW-1:0]    r_lvl, r_below_idx;
    logic [CW-1:0]    r_below;
    logic [VALUE_WIDTH-1:0] r_vout;

    logic [CW-1:0]    w_mid;
    logic [AW:0]      w_cnt_m1;

    // memory ports
    logic                   tail_we, top_we;
    logic [AW-1:0]          tail_wa, tail_ra, top_wa, el_ra, es_ra;
    logic [VALUE_WIDTH-1:0] tail_wd, tail_rd, es_rd;
    logic [AW-1:0]          top_wd, top_rd, lvl_rd;
    logic [CW-1:0]          bel_rd;

    assign w_mid    = r_lo + ((r_hi - r_lo) >> 1);
    assign w_cnt_m1 = (AW+1)'(r_elem_cnt - 1'b1);

    assign o_stat.cmd        = r_cmd;
    assign o_stat.full       = (r_elem_cnt == CW'(MAX_ITEMS));
    assign o_stat.empty      = (r_elem_cnt == '0);
    assign o_stat.range_bad  = (r_k == 11'd0) || (32'(r_k) > 32'(r_lvl_cnt));
    assign o_stat.srch_done  = !(r_lo < r_hi);
    assign o_stat.new_level  = (r_lo == r_lvl_cnt);
    assign o_stat.below_zero = (bel_rd == '0);

    // tail read address
    always_comb begin
        tail_ra = w_mid[AW-1:0];
        if (r_cmd == CMD_TAIL) tail_ra = AW'(r_k - 11'd1);
    end
    assign el_ra = w_cnt_m1[AW-1:0];
    assign es_ra = i_ctrl.pop_b_rd ? AW'(bel_rd - 1'b1) : w_cnt_m1[AW-1:0];

    always_comb begin
        tail_we = 1'b0; tail_wa = r_lo[AW-1:0]; tail_wd = r_value;
        top_we  = 1'b0; top_wa  = r_lo[AW-1:0]; top_wd  = r_elem_cnt[AW-1:0];
        if (i_ctrl.push_wr) begin
            tail_we = 1'b1; top_we = 1'b1;
        end
        if (i_ctrl.pop_wr && !o_stat.below_zero && !i_ctrl.pop_b_rd) begin
            tail_we = 1'b1; tail_wa = r_lvl; tail_wd = es_rd;
            top_we  = 1'b1; top_wa  = r_lvl; top_wd  = r_below_idx;
        end
    end

    lis_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_ITEMS)) u_tail (
        .i_clk, .i_we(tail_we), .i_waddr(tail_wa), .i_wdata(tail_wd),
        .i_raddr(tail_ra), .o_rdata(tail_rd));
    lis_ram #(.WIDTH(AW), .DEPTH(MAX_ITEMS)) u_top (
        .i_clk, .i_we(top_we), .i_waddr(top_wa), .i_wdata(top_wd),
        .i_raddr(r_lo[AW-1:0]), .o_rdata(top_rd));
    lis_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_ITEMS)) u_store (
        .i_clk, .i_we(i_ctrl.push_wr), .i_waddr(r_elem_cnt[AW-1:0]), .i_wdata(r_value),
        .i_raddr(es_ra), .o_rdata(es_rd));
    lis_ram #(.WIDTH(AW), .DEPTH(MAX_ITEMS)) u_level (
        .i_clk, .i_we(i_ctrl.push_wr), .i_waddr(r_elem_cnt[AW-1:0]), .i_wdata(r_lo[AW-1:0]),
        .i_raddr(el_ra), .o_rdata(lvl_rd));
    lis_ram #(.WIDTH(CW), .DEPTH(MAX_ITEMS)) u_below (
        .i_clk, .i_we(i_ctrl.push_wr), .i_waddr(r_elem_cnt[AW-1:0]),
        .i_wdata(o_stat.new_level ? CW'(0) : CW'(top_rd) + CW'(1)),
        .i_raddr(el_ra), .o_rdata(bel_rd));

    logic w_right;
    always_comb begin
        logic [VALUE_WIDTH-1:0] kt, kv;
        kt = tail_rd ^ {1'b1, {(VALUE_WIDTH-1){1'b0}}};
        kv = r_value ^ {1'b1, {(VALUE_WIDTH-1){1'b0}}};
        w_right = i_strict_mode ? (kt < kv) : (kt <= kv);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem_cnt <= '0;
            r_lvl_cnt  <= '0;
        end else begin
            if (i_ctrl.push_wr) begin
                r_elem_cnt <= r_elem_cnt + 1'b1;
                if (o_stat.new_level) r_lvl_cnt <= r_lvl_cnt + 1'b1;
            end
            if (i_ctrl.pop_wr) begin
                r_elem_cnt <= r_elem_cnt - 1'b1;
                // bottom of its level: the popped element sat on the top level
                if (o_stat.below_zero && i_ctrl.pop_b_rd) r_lvl_cnt <= CW'(lvl_rd);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd   <= t_cmd'(i_cmd);
            r_value <= i_value;
            r_k     <= i_length_k;
        end
        if (i_ctrl.srch_init) begin
            r_lo <= '0;
            r_hi <= r_lvl_cnt;
            r_vout <= '0;
            r_status <= ST_OK;
            case (r_cmd)
                CMD_PUSH: if (o_stat.full) r_status <= ST_FULL;
                CMD_POP:  if (o_stat.empty) r_status <= ST_EMPTY;
                CMD_TAIL: if (o_stat.range_bad) r_status <= ST_RANGE;
                default: ;
            endcase
        end
        if (i_ctrl.srch_step) begin
            if (w_right) r_lo <= w_mid + 1'b1;
            else         r_hi <= w_mid;
        end
        if (i_ctrl.pop_b_rd) begin
            r_lvl       <= lvl_rd;
            r_below_idx <= AW'(bel_rd - 1'b1);
            r_vout      <= es_rd;
        end
        if (i_ctrl.tail_cap) r_vout <= tail_rd;
        if (i_ctrl.finish) begin
            o_status        <= r_status;
            o_ending_length <= 11'd0;
            o_value_out     <= '0;
            case (r_cmd)
                CMD_PUSH: begin
                    if (r_status == ST_OK) o_ending_length <= 11'(r_lo) + 11'd1;
                end
                CMD_POP:  o_value_out <= r_vout;
                CMD_TAIL: begin
                    if (r_status == ST_OK) o_value_out <= r_vout;
                end
                default: o_ending_length <= 11'(r_lo) + 11'd1;
            endcase
            o_item_total <= 11'(r_elem_cnt);
            o_lis_length <= 11'(r_lvl_cnt);
        end
    end
endmodule

[sv/lis_tail_tracker_with_undo.sv]
// A length query or a push runs a binary search of at most ceil(log2(levels+1)) probes
// of the tail RAM (registered read), and a push then reads the level top and writes all stores;
// a pop reads its element and the entry beneath, waiting on that read when its level keeps
// elements; a tail query reads the tail RAM; rejected commands go straight to the result.
// One transaction in flight; the next is accepted the cycle after the result is registered.
// Reset (synchronous, active low) clears counts and sets strict mode; RAMs are not cleared.
module lis_tail_tracker_with_undo #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_wdata,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [1:0]             i_cmd,
    input  logic [VALUE_WIDTH-1:0] i_value,
    input  logic [10:0]            i_length_k,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [1:0]             o_status,
    output logic [10:0]            o_item_total,
    output logic [10:0]            o_lis_length,
    output logic [10:0]            o_ending_length,
    output logic [VALUE_WIDTH-1:0] o_value_out
);
    import lis_pkg::*;

    logic  r_strict_mode;
    t_ctrl ctrl;
    t_stat stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_strict_mode <= 1'b1;
        else if (i_cfg_we) r_strict_mode <= i_cfg_wdata;
    end

    lis_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .o_out_valid, .i_out_ready,
        .i_stat(stat), .o_ctrl(ctrl));

    lis_dp #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp (
        .i_clk, .i_rst_n, .i_strict_mode(r_strict_mode), .i_cmd, .i_value, .i_length_k,
        .i_ctrl(ctrl), .o_stat(stat), .o_status, .o_item_total, .o_lis_length,
        .o_ending_length, .o_value_out);
endmodule
